### hw/rtl/length_prefixed_frame_receive_fifo_macros.svh
// Assertion macros used by the frame receive FIFO top level.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVE_FIFO_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVE_FIFO_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define LPF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LPF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define LPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lpf_pkg.sv
// Shared constants, codes and types of the frame receive FIFO.
package lpf_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int HDR_BYTES   = 4;
  localparam int LEN_LO_POS  = 2;
  localparam int POS_W       = 17;
  localparam int LEN_W       = 7;
  localparam int HDR_W       = 8 + 8 + LEN_W;
  localparam int FILL_W      = 4;
  localparam int TDATA_OUT_W = 40;
  localparam int TUSER_OUT_W = 4;

  localparam logic CMD_RX  = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [2:0] KIND_QUEUED    = 3'd0;
  localparam logic [2:0] KIND_DROP_FULL = 3'd1;
  localparam logic [2:0] KIND_TOO_LONG  = 3'd2;
  localparam logic [2:0] KIND_POPPED    = 3'd3;
  localparam logic [2:0] KIND_POP_EMPTY = 3'd4;

  typedef struct packed {
    logic             pay_wr;
    logic [LEN_W-1:0] pay_idx;
    logic             done;
    logic             too_long;
    logic [7:0]       module_id;
    logic [7:0]       function_id;
    logic [LEN_W-1:0] payload_length;
  } rx_evt_t;

endpackage

### hw/rtl/lpf_ram.sv
// Simple dual-port synchronous RAM with registered read.
module lpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/lpf_rx_asm.sv
// Frame assembly: header capture, length tracking and payload indexing.
module lpf_rx_asm #(
  parameter int MAX_PAYLOAD = lpf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_accept,
  input  logic [7:0]       rx_byte,
  output lpf_pkg::rx_evt_t evt
);

  logic [lpf_pkg::POS_W-1:0] pos;
  logic [lpf_pkg::POS_W-1:0] expected;
  logic [31:0]               hdr;

  logic                      in_hdr;
  logic [31:0]               hdr_next;
  logic [15:0]               len16;
  logic [lpf_pkg::POS_W-1:0] exp_now;
  logic [lpf_pkg::POS_W-1:0] pos_inc;
  logic [lpf_pkg::POS_W-1:0] idx;

  always_comb begin
    in_hdr   = pos < lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES);
    hdr_next = hdr;
    if (in_hdr) begin
      hdr_next[8*pos[1:0] +: 8] = rx_byte;
    end
    len16   = hdr_next[31:16];
    exp_now = (pos == lpf_pkg::POS_W'(lpf_pkg::LEN_LO_POS + 1))
            ? lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES) + lpf_pkg::POS_W'(len16)
            : expected;
    pos_inc = pos + 1'b1;
    idx     = pos - lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES);

    evt.pay_wr         = !in_hdr && (idx < lpf_pkg::POS_W'(MAX_PAYLOAD));
    evt.pay_idx        = idx[lpf_pkg::LEN_W-1:0];
    evt.done           = pos_inc >= exp_now;
    evt.too_long       = len16 > 16'(MAX_PAYLOAD);
    evt.module_id      = hdr_next[7:0];
    evt.function_id    = hdr_next[15:8];
    evt.payload_length = evt.too_long ? '0 : len16[lpf_pkg::LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      expected <= lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES);
      hdr      <= '0;
    end else if (byte_accept) begin
      if (evt.done) begin
        pos      <= '0;
        expected <= lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES);
        hdr      <= '0;
      end else begin
        pos      <= pos_inc;
        expected <= exp_now;
        hdr      <= hdr_next;
      end
    end
  end

endmodule

### hw/rtl/length_prefixed_frame_receive_fifo.sv
// Top level: frame receiver with a ring FIFO of frames held in RAM.
//
//  channel   dir  fields
//  s_axis    in   tuser: command; tdata: rx_byte
//  m_axis    out  tuser: kind, byte_valid; tlast: last;
//                 tdata: module_id, function_id, payload_length, data_byte, fill_count
//
// A received byte is written as it is accepted; a pop first reads the header and
// first payload byte, then gives one beat per payload byte (a single beat for an empty
// payload), paced by the registered payload RAM read. Input is held off during a pop.
// Reset is synchronous and clears the pointers and frame state; the RAMs need no clearing.
// A stalled output holds the input off until the waiting beat is taken.
`include "length_prefixed_frame_receive_fifo_macros.svh"

module length_prefixed_frame_receive_fifo #(
  parameter int QUEUE_DEPTH = lpf_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_PAYLOAD = lpf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [7:0] rx_byte
  input  logic                            s_axis_tuser,  // [0] command
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [7:0] module_id, [15:8] function_id, [22:16] payload_length,
  // [30:23] data_byte, [34:31] fill_count, [39:35] zero
  output logic [lpf_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic [lpf_pkg::TUSER_OUT_W-1:0] m_axis_tuser,  // [2:0] kind, [3] byte_valid
  output logic                            m_axis_tlast
);

  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PAY_D   = QUEUE_DEPTH * MAX_PAYLOAD;
  localparam int ADDR_W  = $clog2(PAY_D);
  localparam int LEN_W   = lpf_pkg::LEN_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic              state;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] pop_slot;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [LEN_W-1:0]  idx;

  logic                       out_valid;
  logic [2:0]                 out_kind;
  logic [7:0]                 out_mod;
  logic [7:0]                 out_fn;
  logic [LEN_W-1:0]           out_len;
  logic [7:0]                 out_data;
  logic                       out_bv;
  logic                       out_last;
  logic [lpf_pkg::FILL_W-1:0] out_fill;

  lpf_pkg::rx_evt_t     evt;
  logic                 out_free;
  logic                 in_acc;
  logic                 rx_acc;
  logic                 pop_acc;
  logic                 pop_start;
  logic                 full;
  logic                 queue_frame;
  logic                 pop_emit;
  logic                 pop_last;
  logic [SLOT_W-1:0]    wr_slot_inc;
  logic [SLOT_W-1:0]    rd_slot_inc;

  logic                 hdr_wr;
  logic [lpf_pkg::HDR_W-1:0] hdr_wdata;
  logic [lpf_pkg::HDR_W-1:0] hdr_rdata;
  logic [7:0]           h_mod;
  logic [7:0]           h_fn;
  logic [LEN_W-1:0]     h_len;

  logic                 pay_wr;
  logic [ADDR_W-1:0]    pay_waddr;
  logic                 pay_rd;
  logic [ADDR_W-1:0]    pay_raddr;
  logic [7:0]           pay_rdata;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rx_acc        = in_acc && (s_axis_tuser == lpf_pkg::CMD_RX);
  assign pop_acc       = in_acc && (s_axis_tuser == lpf_pkg::CMD_POP);
  assign full          = count >= CNT_W'(QUEUE_DEPTH);
  assign pop_start     = pop_acc && (count != '0);
  assign queue_frame   = rx_acc && evt.done && !evt.too_long && !full;

  assign wr_slot_inc = (wr_slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
  assign rd_slot_inc = (rd_slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : rd_slot + 1'b1;

  assign {h_len, h_fn, h_mod} = hdr_rdata;
  assign pop_emit = (state == ST_POP) && out_free;
  assign pop_last = (h_len == '0) || (idx + 1'b1 == h_len);

  always_comb begin
    count_next = count;
    if (queue_frame) begin
      count_next = count + 1'b1;
    end else if (pop_start) begin
      count_next = count - 1'b1;
    end
  end

  assign hdr_wr    = queue_frame;
  assign hdr_wdata = {evt.payload_length, evt.function_id, evt.module_id};

  assign pay_wr    = rx_acc && evt.pay_wr && !full;
  assign pay_waddr = ADDR_W'(wr_slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(evt.pay_idx);
  assign pay_rd    = pop_start || (pop_emit && !pop_last);
  assign pay_raddr = pop_start
                   ? ADDR_W'(rd_slot) * ADDR_W'(MAX_PAYLOAD)
                   : ADDR_W'(pop_slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(idx + 1'b1);

  lpf_rx_asm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_rx_asm (
    .clk         (clk),
    .rst         (rst),
    .byte_accept (rx_acc),
    .rx_byte     (s_axis_tdata),
    .evt         (evt)
  );

  lpf_ram #(
    .WIDTH (lpf_pkg::HDR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (hdr_wr),
    .wr_addr (wr_slot),
    .wr_data (hdr_wdata),
    .rd_en   (pop_start),
    .rd_addr (rd_slot),
    .rd_data (hdr_rdata)
  );

  lpf_ram #(
    .WIDTH (8),
    .DEPTH (PAY_D)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (pay_wr),
    .wr_addr (pay_waddr),
    .wr_data (s_axis_tdata),
    .rd_en   (pay_rd),
    .rd_addr (pay_raddr),
    .rd_data (pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wr_slot <= '0;
      rd_slot <= '0;
      count   <= '0;
      idx     <= '0;
    end else begin
      count <= count_next;
      if (queue_frame) begin
        wr_slot <= wr_slot_inc;
      end
      if (pop_start) begin
        state    <= ST_POP;
        pop_slot <= rd_slot;
        rd_slot  <= rd_slot_inc;
        idx      <= '0;
      end else if (pop_emit) begin
        if (pop_last) begin
          state <= ST_IDLE;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_acc && evt.done) begin
      out_valid <= 1'b1;
      if (evt.too_long) begin
        out_kind <= lpf_pkg::KIND_TOO_LONG;
      end else if (full) begin
        out_kind <= lpf_pkg::KIND_DROP_FULL;
      end else begin
        out_kind <= lpf_pkg::KIND_QUEUED;
      end
      out_mod  <= evt.module_id;
      out_fn   <= evt.function_id;
      out_len  <= evt.payload_length;
      out_data <= '0;
      out_bv   <= 1'b0;
      out_last <= 1'b1;
      out_fill <= lpf_pkg::FILL_W'(count_next);
    end else if (pop_acc && !pop_start) begin
      out_valid <= 1'b1;
      out_kind  <= lpf_pkg::KIND_POP_EMPTY;
      out_mod   <= '0;
      out_fn    <= '0;
      out_len   <= '0;
      out_data  <= '0;
      out_bv    <= 1'b0;
      out_last  <= 1'b1;
      out_fill  <= lpf_pkg::FILL_W'(count);
    end else if (pop_emit) begin
      out_valid <= 1'b1;
      out_kind  <= lpf_pkg::KIND_POPPED;
      out_mod   <= h_mod;
      out_fn    <= h_fn;
      out_len   <= h_len;
      out_data  <= (h_len == '0) ? '0 : pay_rdata;
      out_bv    <= h_len != '0;
      out_last  <= pop_last;
      out_fill  <= lpf_pkg::FILL_W'(count);
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_fill, out_data, out_len, out_fn, out_mod};
  assign m_axis_tuser  = {out_bv, out_kind};
  assign m_axis_tlast  = out_last;

  `LPF_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "frame count exceeds depth")
  `LPF_ASSERT_NEXT(a_pop_empty, pop_acc && (count == '0), out_valid && (out_kind == lpf_pkg::KIND_POP_EMPTY), "pop on empty FIFO gave no error beat")
  `LPF_ASSERT_NEXT(a_pop_end, pop_emit && pop_last, (state == ST_IDLE) && out_last, "pop did not end on its last beat")
  `LPF_ASSERT_SAME(a_no_rw_mix, pay_wr, !pay_rd, "payload RAM written during a pop read")
  `LPF_ASSERT_NEXT(a_count_step, pop_start, count == $past(count) - 1'b1, "pop did not release one frame")

endmodule

### dv/length_prefixed_frame_receive_fifo_tb.sv
// Testbench for the frame receive FIFO: directed table, then random frames and pops with a predictor.
module length_prefixed_frame_receive_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = lpf_pkg::QUEUE_DEPTH_DEF;
  localparam int MAXPAY = lpf_pkg::MAX_PAYLOAD_DEF;
  localparam int RAND_ITEMS = 100;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [2:0]                kind;
    logic [7:0]                module_id;
    logic [7:0]                function_id;
    logic [lpf_pkg::LEN_W-1:0] payload_length;
    logic [7:0]                data_byte;
    logic                      byte_valid;
    logic                      last;
    logic [3:0]                fill_count;
  } beat_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rx;
    logic [15:0] reps;
    logic        typed;
    beat_t       want;
  } row_t;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [lpf_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
  logic [lpf_pkg::TUSER_OUT_W-1:0] m_axis_tuser;
  logic                            m_axis_tlast;

  logic  typed_on;
  beat_t typed_beat;

  // receiver-side frame state
  logic [lpf_pkg::POS_W-1:0] rx_pos;
  logic [lpf_pkg::POS_W-1:0] rx_total;
  logic [31:0]               rx_header;
  logic [23:0]               slot_header [DEPTH];
  logic [7:0]                slot_payload [DEPTH*MAXPAY];
  bit                        slot_written [DEPTH*MAXPAY];
  int                        wr_ptr;
  int                        rd_ptr;
  int                        held_frames;

  beat_t due_beats [$];
  int    errors;
  int    cycles;
  int    items_in;
  int    beats_out;
  int    kind_seen [5];
  int    squeezes_asked;
  int    squeezes_done;
  bit    sender_quiet;

  row_t script [23] = '{
    '{lpf_pkg::CMD_POP, 'h00,  1, 1, '{lpf_pkg::KIND_POP_EMPTY, 'h00, 'h00,  0, 0, 0, 1, 0}},
    '{lpf_pkg::CMD_RX,  'h00,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h00,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h00,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h00,  1, 1, '{lpf_pkg::KIND_QUEUED,    'h00, 'h00,  0, 0, 0, 1, 1}},
    '{lpf_pkg::CMD_POP, 'hFF,  1, 1, '{lpf_pkg::KIND_POPPED,    'h00, 'h00,  0, 0, 0, 1, 0}},
    '{lpf_pkg::CMD_RX,  'hFF,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'hFF,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h40,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h00,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h80, 64, 1, '{lpf_pkg::KIND_QUEUED,    'hFF, 'hFF, 64, 0, 0, 1, 1}},
    '{lpf_pkg::CMD_POP, 'h5A,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h12,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h34,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h41,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h00,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'hC0, 65, 1, '{lpf_pkg::KIND_TOO_LONG,  'h12, 'h34,  0, 0, 0, 1, 0}},
    '{lpf_pkg::CMD_RX,  'h7E,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h81,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h01,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'h00,  1, 0, '0},
    '{lpf_pkg::CMD_RX,  'hFF,  1, 1, '{lpf_pkg::KIND_QUEUED,    'h7E, 'h81,  1, 0, 0, 1, 1}},
    '{lpf_pkg::CMD_POP, 'h00,  1, 0, '0}
  };

  length_prefixed_frame_receive_fifo u_top (
    .clk,
    .rst,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void frame_fifo_step(input logic cmd, input logic [7:0] rx);
    beat_t b;
    int len;
    int slot;
    int idx;
    b = '0;
    b.last = 1'b1;
    if (cmd == lpf_pkg::CMD_POP) begin
      if (held_frames == 0) begin
        b.kind = lpf_pkg::KIND_POP_EMPTY;
        due_beats.push_back(b);
        return;
      end
      slot = rd_ptr;
      len = int'(slot_header[slot][23:16]);
      if (len > MAXPAY) len = MAXPAY;
      rd_ptr = (rd_ptr + 1) % DEPTH;
      held_frames--;
      b.kind = lpf_pkg::KIND_POPPED;
      b.module_id = slot_header[slot][7:0];
      b.function_id = slot_header[slot][15:8];
      b.fill_count = held_frames[3:0];
      if (len == 0) begin
        due_beats.push_back(b);
        return;
      end
      b.payload_length = lpf_pkg::LEN_W'(len);
      b.byte_valid = 1'b1;
      for (int i = 0; i < len; i++) begin
        b.data_byte = slot_payload[slot*MAXPAY + i];
        b.last = (i == len - 1);
        due_beats.push_back(b);
      end
      return;
    end
    if (rx_pos < lpf_pkg::HDR_BYTES) begin
      rx_header[8*rx_pos +: 8] = rx;
      if (rx_pos == lpf_pkg::LEN_LO_POS + 1)
        rx_total = lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES + int'(rx_header[31:16]));
    end else begin
      idx = int'(rx_pos) - lpf_pkg::HDR_BYTES;
      if (idx < MAXPAY && held_frames < DEPTH) begin
        slot_payload[wr_ptr*MAXPAY + idx] = rx;
        slot_written[wr_ptr*MAXPAY + idx] = 1'b1;
      end
    end
    rx_pos = rx_pos + 1'b1;
    if (rx_pos < rx_total) return;
    len = int'(rx_header[31:16]);
    b.module_id = rx_header[7:0];
    b.function_id = rx_header[15:8];
    if (len > MAXPAY) begin
      b.kind = lpf_pkg::KIND_TOO_LONG;
    end else if (held_frames >= DEPTH) begin
      b.kind = lpf_pkg::KIND_DROP_FULL;
      b.payload_length = lpf_pkg::LEN_W'(len);
    end else begin
      b.kind = lpf_pkg::KIND_QUEUED;
      b.payload_length = lpf_pkg::LEN_W'(len);
      slot_header[wr_ptr] = rx_header[23:0];
      wr_ptr = (wr_ptr + 1) % DEPTH;
      held_frames++;
    end
    b.fill_count = held_frames[3:0];
    due_beats.push_back(b);
    rx_pos = '0;
    rx_total = lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES);
    rx_header = '0;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= 50) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic void check_beat();
    beat_t got;
    beat_t want;
    got = '{m_axis_tuser[2:0], m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[22:16],
            m_axis_tdata[30:23], m_axis_tuser[3], m_axis_tlast, m_axis_tdata[34:31]};
    beats_out++;
    if (got.kind <= lpf_pkg::KIND_POP_EMPTY) kind_seen[got.kind]++;
    if (due_beats.size() == 0) begin
      errors++;
      if (errors <= 50) $error("unexpected output beat: kind %0d", got.kind);
      return;
    end
    want = due_beats.pop_front();
    check_field("kind", 8'(want.kind), 8'(got.kind));
    check_field("module_id", want.module_id, got.module_id);
    check_field("function_id", want.function_id, got.function_id);
    check_field("payload_length", 8'(want.payload_length), 8'(got.payload_length));
    check_field("data_byte", want.data_byte, got.data_byte);
    check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
    check_field("last", 8'(want.last), 8'(got.last));
    check_field("fill_count", 8'(want.fill_count), 8'(got.fill_count));
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        frame_fifo_step(s_axis_tuser, s_axis_tdata);
        if (typed_on) begin
          void'(due_beats.pop_back());
          due_beats.push_back(typed_beat);
        end
        items_in++;
      end
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
  end

  // A pop while full mid-frame must not expose payload slots never written.
  function automatic bit pop_is_safe();
    int n;
    int len;
    if (held_frames != DEPTH || rx_pos <= lpf_pkg::HDR_BYTES) return 1'b1;
    len = int'(rx_header[31:16]);
    if (len > MAXPAY) return 1'b1;
    n = int'(rx_pos) - lpf_pkg::HDR_BYTES;
    if (n > len) n = len;
    for (int i = 0; i < n; i++)
      if (!slot_written[wr_ptr*MAXPAY + i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 90) return $urandom_range(4, 12);
    if (r < 96) return $urandom_range(MAXPAY - 2, MAXPAY);
    return $urandom_range(MAXPAY + 1, MAXPAY + 2);
  endfunction

  // Keep stray header bytes from announcing huge frames.
  function automatic logic [7:0] fill_byte();
    if (rx_pos == lpf_pkg::LEN_LO_POS) return 8'($urandom_range(0, MAXPAY + 6));
    if (rx_pos == lpf_pkg::LEN_LO_POS + 1) return 8'h00;
    return 8'($urandom);
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] rx, input bit typed = 1'b0,
                           input beat_t fixed = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= rx;
    typed_on <= typed;
    typed_beat <= fixed;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_pop();
    if (pop_is_safe()) send_item(lpf_pkg::CMD_POP, 8'($urandom));
    else send_item(lpf_pkg::CMD_RX, fill_byte());
  endtask

  task automatic send_frame(input int len);
    logic [31:0] hdr;
    while (rx_pos != 0) send_item(lpf_pkg::CMD_RX, fill_byte());
    hdr = {16'(len), 8'($urandom), 8'($urandom)};
    for (int k = 0; k < lpf_pkg::HDR_BYTES + len; k++) begin
      if (($urandom_range(0, 30) == 0 || (held_frames == DEPTH && $urandom_range(0, 2) == 0))
          && pop_is_safe())
        send_item(lpf_pkg::CMD_POP, 8'($urandom));
      send_item(lpf_pkg::CMD_RX, (k < lpf_pkg::HDR_BYTES) ? hdr[8*k +: 8] : 8'($urandom));
    end
  endtask

  initial begin : sink
    int stall_left;
    int quiet_left;
    int r;
    stall_left = 0;
    quiet_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (squeezes_done != squeezes_asked) begin
        squeezes_done++;
        m_axis_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (quiet_left > 0) begin
          quiet_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 2) quiet_left = $urandom_range(40, 150);
          else if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 23) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : stimulus
    int directed_items;
    int round;
    int r;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = lpf_pkg::CMD_RX;
    typed_on = 1'b0;
    typed_beat = '0;
    rx_pos = '0;
    rx_total = lpf_pkg::POS_W'(lpf_pkg::HDR_BYTES);
    rx_header = '0;
    wr_ptr = 0;
    rd_ptr = 0;
    held_frames = 0;
    sender_quiet = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      for (int k = 0; k < script[i].reps; k++)
        send_item(script[i].cmd, script[i].rx + 8'(k),
                  script[i].typed && (k == script[i].reps - 1), script[i].want);
    directed_items = items_in;

    round = 0;
    while (items_in - directed_items < RAND_ITEMS) begin
      round++;
      sender_quiet = ($urandom_range(0, 3) == 0);
      if (round == 1 || round == 6) begin
        squeezes_asked++;
        repeat (DEPTH + 2) send_frame(0);
        send_frame($urandom_range(3, 8));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          repeat ($urandom_range(1, 5)) send_frame(pick_len());
        end else if (r < 90) begin
          repeat ($urandom_range(1, 6)) send_pop();
        end else begin
          repeat ($urandom_range(1, 3)) send_item(lpf_pkg::CMD_RX, fill_byte());
          send_pop();
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run: %0d input beats (%0d from the table), %0d output beats, %0d mismatches.",
             items_in, directed_items, beats_out, errors);
    $display("Seen: %0d queued, %0d full drops, %0d long drops, %0d popped, %0d empty pops.",
             kind_seen[lpf_pkg::KIND_QUEUED], kind_seen[lpf_pkg::KIND_DROP_FULL],
             kind_seen[lpf_pkg::KIND_TOO_LONG], kind_seen[lpf_pkg::KIND_POPPED],
             kind_seen[lpf_pkg::KIND_POP_EMPTY]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/lpf_pkg.sv
hw/rtl/lpf_ram.sv
hw/rtl/lpf_rx_asm.sv
hw/rtl/length_prefixed_frame_receive_fifo.sv
dv/length_prefixed_frame_receive_fifo_tb.sv
